>>> rtl/ibwt_pkg.sv
// ibwt_pkg: shared types and constants of the inverse bwt decoder
// used by ibwt_ctrl, ibwt_dp and inverse_bwt_decoder_top; no dependencies
package ibwt_pkg;

    localparam int MAX_BLOCK = 65536;
    localparam int ALPHABET  = 256;
    localparam int ADDR_W    = $clog2(MAX_BLOCK);
    localparam int LEN_W     = ADDR_W + 1;
    localparam int SYM_W     = 8;
    localparam int CNT_AW    = $clog2(ALPHABET);

    typedef struct packed {
        logic             action;
        logic [SYM_W-1:0] symbol;
        logic             block_end;
    } item_t;

    typedef struct packed {
        logic [SYM_W-1:0] text_byte;
        logic             final_byte;
        logic [1:0]       status;
    } result_t;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_FETCH = 1'b1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NONE = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    typedef enum logic [1:0] {
        PH_LOAD  = 2'd0,
        PH_FETCH = 2'd1,
        PH_DONE  = 2'd2,
        PH_ERROR = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        FK_ERR  = 2'd0,
        FK_NONE = 2'd1,
        FK_END  = 2'd2,
        FK_BYTE = 2'd3
    } fetch_kind_t;

    typedef struct packed {
        logic load_acc;
        logic fetch_acc;
        logic load_upd;
        logic fin_check;
        logic sent_rd;
        logic sent_cnt;
        logic sent_wr;
        logic pfx_rd;
        logic pfx_wr;
        logic lnk_sym;
        logic lnk_cnt;
        logic lnk_wr;
        logic walk_rd;
        logic walk_set;
        logic fetch_out;
    } dp_cmd_t;

    typedef struct packed {
        logic block_end;
        logic fin_err;
        logic is_sent;
        logic pfx_last;
        logic lnk_last;
        logic out_free;
    } dp_stat_t;

endpackage

>>> rtl/inverse_bwt_decoder_top.sv
// inverse_bwt_decoder_top: top level of the inverse bwt decoder
// depends on ibwt_pkg, ibwt_ctrl and ibwt_dp
//
// usage: load items (action 0) carry one transformed byte each; the one
// marked block_end closes the block and samples sentinel_row, written
// beforehand over the cfg_valid/cfg_ready/cfg_data channel (always ready).
// fetch items (action 1) each return one result: a text byte in order,
// "no text pending" or "block too long / bad sentinel row".
// loads give no result; each is a count read-modify-write unless the block is full.
// a block-end load then runs a length and sentinel row check (an error ends it
// there), a histogram fix-up, a prefix-sum sweep over the count memory, a link
// build pass over the rows through the symbol and count memories, and a walk start.
// a fetch does one registered read of the link and first-column memories,
// then loads the result register once it is free; one item is in work at a time.
// item_stall is high while an item is in work; a stalled result holds in
// its output register and a pending fetch waits for it to be taken.
// reset: block empty, counts cleared, sentinel_row 0, no result pending.
module inverse_bwt_decoder_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ibwt_pkg::item_t             item,
    input  logic                        item_valid,
    output logic                        item_stall,
    output ibwt_pkg::result_t           result,
    output logic                        result_valid,
    input  logic                        result_stall,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [ibwt_pkg::ADDR_W-1:0] cfg_data
);

    ibwt_pkg::dp_cmd_t  cmd;
    ibwt_pkg::dp_stat_t stat;

    ibwt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .action     (item.action),
        .item_stall (item_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    ibwt_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd),
        .stat         (stat)
    );

`ifndef ASSERT_OFF
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command at once");

    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall && item.action == ibwt_pkg::ACT_LOAD)
            |=> !cmd.fetch_out)
        else $error("load transfer produced a result");

    a_nonbyte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status != ibwt_pkg::ST_OK)
            |-> (result.text_byte == '0 && !result.final_byte))
        else $error("status without byte carries data");
`endif

endmodule

>>> rtl/ibwt_ctrl.sv
// ibwt_ctrl: sequencing state machine of the inverse bwt decoder
// depends on ibwt_pkg; drives dp_cmd_t commands into ibwt_dp
module ibwt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              action,
    output logic              item_stall,
    input  ibwt_pkg::dp_stat_t stat,
    output ibwt_pkg::dp_cmd_t  cmd
);

    typedef enum logic [14:0] {
        S_IDLE      = 15'h0001,
        S_LOAD_UPD  = 15'h0002,
        S_FIN_CHECK = 15'h0004,
        S_SENT_RD   = 15'h0008,
        S_SENT_CNT  = 15'h0010,
        S_SENT_WR   = 15'h0020,
        S_PFX_RD    = 15'h0040,
        S_PFX_WR    = 15'h0080,
        S_LNK_SYM   = 15'h0100,
        S_LNK_CNT   = 15'h0200,
        S_LNK_WR    = 15'h0400,
        S_WALK_RD   = 15'h0800,
        S_WALK_SET  = 15'h1000,
        S_FETCH_OUT = 15'h2000,
        S_SPARE     = 15'h4000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign item_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    if (action == ibwt_pkg::ACT_FETCH)
                    begin
                        cmd.fetch_acc = 1'b1;
                        state_next    = S_FETCH_OUT;
                    end
                    else
                    begin
                        cmd.load_acc = 1'b1;
                        state_next   = S_LOAD_UPD;
                    end
                end
            end
            S_LOAD_UPD:
            begin
                cmd.load_upd = 1'b1;
                state_next   = stat.block_end ? S_FIN_CHECK : S_IDLE;
            end
            S_FIN_CHECK:
            begin
                cmd.fin_check = 1'b1;
                state_next    = stat.fin_err ? S_IDLE : S_SENT_RD;
            end
            S_SENT_RD:
            begin
                cmd.sent_rd = 1'b1;
                state_next  = S_SENT_CNT;
            end
            S_SENT_CNT:
            begin
                cmd.sent_cnt = 1'b1;
                state_next   = S_SENT_WR;
            end
            S_SENT_WR:
            begin
                cmd.sent_wr = 1'b1;
                state_next  = S_PFX_RD;
            end
            S_PFX_RD:
            begin
                cmd.pfx_rd = 1'b1;
                state_next = S_PFX_WR;
            end
            S_PFX_WR:
            begin
                cmd.pfx_wr = 1'b1;
                state_next = stat.pfx_last ? S_LNK_SYM : S_PFX_RD;
            end
            S_LNK_SYM:
            begin
                cmd.lnk_sym = 1'b1;
                state_next  = S_LNK_CNT;
            end
            S_LNK_CNT:
            begin
                cmd.lnk_cnt = 1'b1;
                // sentinel row gets link 0 right here
                if (stat.is_sent)
                    state_next = stat.lnk_last ? S_WALK_RD : S_LNK_SYM;
                else
                    state_next = S_LNK_WR;
            end
            S_LNK_WR:
            begin
                cmd.lnk_wr = 1'b1;
                state_next = stat.lnk_last ? S_WALK_RD : S_LNK_SYM;
            end
            S_WALK_RD:
            begin
                cmd.walk_rd = 1'b1;
                state_next  = S_WALK_SET;
            end
            S_WALK_SET:
            begin
                cmd.walk_set = 1'b1;
                state_next   = S_IDLE;
            end
            S_FETCH_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.fetch_out = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> rtl/ibwt_dp.sv
// ibwt_dp: datapath of the inverse bwt decoder with block, link, column and count memories
// depends on ibwt_pkg; commanded by ibwt_ctrl
module ibwt_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ibwt_pkg::item_t                     item,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ibwt_pkg::ADDR_W-1:0]         cfg_data,
    output ibwt_pkg::result_t                   result,
    output logic                                result_valid,
    input  logic                                result_stall,
    input  ibwt_pkg::dp_cmd_t                   cmd,
    output ibwt_pkg::dp_stat_t                  stat
);

    localparam int AW  = ibwt_pkg::ADDR_W;
    localparam int LW  = ibwt_pkg::LEN_W;
    localparam int SW  = ibwt_pkg::SYM_W;
    localparam int CAW = ibwt_pkg::CNT_AW;
    localparam logic [LW-1:0] MAX_LEN = LW'(ibwt_pkg::MAX_BLOCK);

    // memories
    logic [SW-1:0] sym_mem  [ibwt_pkg::MAX_BLOCK];
    logic [AW-1:0] link_mem [ibwt_pkg::MAX_BLOCK];
    logic [SW-1:0] fcol_mem [ibwt_pkg::MAX_BLOCK];
    logic [LW-1:0] cnt_mem  [ibwt_pkg::ALPHABET];

    logic [AW-1:0]  sent_cfg_reg;
    logic [AW-1:0]  sent_reg;
    logic [LW-1:0]  len_reg;
    logic [LW-1:0]  idx_reg;
    logic [LW-1:0]  total_reg;
    logic [AW-1:0]  walk_reg;
    logic [LW-1:0]  emitted_reg;
    ibwt_pkg::phase_t      phase_reg;
    ibwt_pkg::fetch_kind_t kind_reg;
    logic           store_ok_reg;
    logic           last_reg;
    logic [CAW-1:0] cnt_addr_reg;
    logic [ibwt_pkg::ALPHABET-1:0] cnt_vld_reg;
    logic [SW-1:0]  sym_q_reg;
    logic [LW-1:0]  cnt_q_reg;
    logic [AW-1:0]  link_q_reg;
    logic [SW-1:0]  fcol_q_reg;
    ibwt_pkg::result_t out_reg;
    logic           out_valid_reg;

    logic           clear;
    logic [LW-1:0]  len_eff;
    logic [LW-1:0]  cnt_eff;
    logic           cnt_re;
    logic [CAW-1:0] cnt_raddr;
    logic           cnt_we;
    logic [LW-1:0]  cnt_wdata;
    logic [AW-1:0]  sym_raddr;
    logic           link_we;
    logic [AW-1:0]  link_wdata;
    logic [AW-1:0]  link_raddr;
    logic [LW-1:0]  text_size;
    logic           is_final;
    ibwt_pkg::fetch_kind_t kind_now;

    assign cfg_ready    = 1'b1;
    assign result       = out_reg;
    assign result_valid = out_valid_reg;

    assign clear     = (phase_reg != ibwt_pkg::PH_LOAD);
    assign len_eff   = clear ? '0 : len_reg;
    // entries not written since the block started read as zero
    assign cnt_eff   = cnt_vld_reg[cnt_addr_reg] ? cnt_q_reg : '0;
    assign text_size = len_reg - LW'(1);
    assign is_final  = ((emitted_reg + LW'(1)) == text_size);

    assign stat.block_end = last_reg;
    assign stat.fin_err   = (len_reg > MAX_LEN) || ({1'b0, sent_reg} >= len_reg);
    assign stat.is_sent   = (idx_reg[AW-1:0] == sent_reg);
    assign stat.pfx_last  = (idx_reg[CAW-1:0] == CAW'(ibwt_pkg::ALPHABET - 1));
    assign stat.lnk_last  = ((idx_reg + LW'(1)) == len_reg);
    assign stat.out_free  = !out_valid_reg || !result_stall;

    always_comb
    begin
        priority if (phase_reg == ibwt_pkg::PH_ERROR)
            kind_now = ibwt_pkg::FK_ERR;
        else if (phase_reg != ibwt_pkg::PH_FETCH)
            kind_now = ibwt_pkg::FK_NONE;
        else if ((emitted_reg >= text_size) || (walk_reg == '0) || ({1'b0, walk_reg} >= len_reg))
            kind_now = ibwt_pkg::FK_END;
        else
            kind_now = ibwt_pkg::FK_BYTE;
    end

    // count memory port selection
    always_comb
    begin
        cnt_re    = 1'b0;
        cnt_raddr = sym_q_reg[CAW-1:0];
        if (cmd.load_acc)
        begin
            cnt_re    = 1'b1;
            cnt_raddr = item.symbol[CAW-1:0];
        end
        else if (cmd.pfx_rd)
        begin
            cnt_re    = 1'b1;
            cnt_raddr = idx_reg[CAW-1:0];
        end
        else if (cmd.sent_cnt || (cmd.lnk_cnt && !stat.is_sent))
        begin
            cnt_re = 1'b1;
        end
    end

    always_comb
    begin
        cnt_we    = 1'b0;
        cnt_wdata = cnt_eff + LW'(1);
        if (cmd.load_upd && store_ok_reg)
            cnt_we = 1'b1;
        else if (cmd.lnk_wr)
            cnt_we = 1'b1;
        else if (cmd.sent_wr)
        begin
            cnt_we    = 1'b1;
            cnt_wdata = cnt_eff - LW'(1);
        end
        else if (cmd.pfx_wr)
        begin
            cnt_we    = 1'b1;
            cnt_wdata = total_reg;
        end
    end

    assign sym_raddr  = cmd.sent_rd ? sent_reg : idx_reg[AW-1:0];
    assign link_we    = (cmd.lnk_cnt && stat.is_sent) || cmd.lnk_wr;
    assign link_wdata = cmd.lnk_wr ? AW'(cnt_eff + LW'(1)) : '0;
    assign link_raddr = cmd.walk_rd ? '0 : walk_reg;

    always_ff @(posedge clk)
    begin
        if (cnt_we)
            cnt_mem[cnt_addr_reg] <= cnt_wdata;
        if (cnt_re)
            cnt_q_reg <= cnt_mem[cnt_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_acc && (len_eff < MAX_LEN))
            sym_mem[len_eff[AW-1:0]] <= item.symbol;
        if (cmd.sent_rd || cmd.lnk_sym)
            sym_q_reg <= sym_mem[sym_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
            link_mem[idx_reg[AW-1:0]] <= link_wdata;
        if (cmd.walk_rd || cmd.fetch_acc)
            link_q_reg <= link_mem[link_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lnk_wr)
            fcol_mem[cnt_eff[AW-1:0]] <= sym_q_reg;
        if (cmd.fetch_acc)
            fcol_q_reg <= fcol_mem[walk_reg - AW'(1)];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cnt_re)
            cnt_addr_reg <= cnt_raddr;
        if (cmd.load_acc)
        begin
            sent_reg     <= sent_cfg_reg;
            store_ok_reg <= (len_eff < MAX_LEN);
            last_reg     <= item.block_end;
        end
        if (cmd.fetch_acc)
            kind_reg <= kind_now;
        if (cmd.fin_check)
        begin
            idx_reg   <= '0;
            total_reg <= '0;
        end
        if (cmd.pfx_wr)
        begin
            total_reg <= total_reg + cnt_eff;
            idx_reg   <= stat.pfx_last ? '0 : idx_reg + LW'(1);
        end
        if (cmd.lnk_wr || (cmd.lnk_cnt && stat.is_sent))
            idx_reg <= idx_reg + LW'(1);
        if (cmd.fetch_out)
        begin
            out_reg.text_byte  <= '0;
            out_reg.final_byte <= 1'b0;
            unique case (kind_reg)
                ibwt_pkg::FK_ERR:  out_reg.status <= ibwt_pkg::ST_ERR;
                ibwt_pkg::FK_NONE: out_reg.status <= ibwt_pkg::ST_NONE;
                ibwt_pkg::FK_END:  out_reg.status <= ibwt_pkg::ST_NONE;
                ibwt_pkg::FK_BYTE:
                begin
                    out_reg.status     <= ibwt_pkg::ST_OK;
                    out_reg.text_byte  <= fcol_q_reg;
                    out_reg.final_byte <= is_final;
                end
                default: out_reg.status <= ibwt_pkg::ST_NONE;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sent_cfg_reg  <= '0;
            len_reg       <= '0;
            walk_reg      <= '0;
            emitted_reg   <= '0;
            phase_reg     <= ibwt_pkg::PH_LOAD;
            cnt_vld_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                sent_cfg_reg <= cfg_data;
            if (cmd.load_acc && clear)
            begin
                cnt_vld_reg <= '0;
                len_reg     <= '0;
                walk_reg    <= '0;
                emitted_reg <= '0;
                phase_reg   <= ibwt_pkg::PH_LOAD;
            end
            if (cnt_we)
                cnt_vld_reg[cnt_addr_reg] <= 1'b1;
            if (cmd.load_upd)
                len_reg <= store_ok_reg ? len_reg + LW'(1) : MAX_LEN + LW'(1);
            if (cmd.fin_check && stat.fin_err)
                phase_reg <= ibwt_pkg::PH_ERROR;
            if (cmd.walk_set)
            begin
                walk_reg    <= link_q_reg;
                emitted_reg <= '0;
                phase_reg   <= ibwt_pkg::PH_FETCH;
            end
            if (cmd.fetch_out)
            begin
                if (kind_reg == ibwt_pkg::FK_BYTE)
                begin
                    walk_reg    <= link_q_reg;
                    emitted_reg <= emitted_reg + LW'(1);
                    if (is_final)
                        phase_reg <= ibwt_pkg::PH_DONE;
                end
                else if (kind_reg == ibwt_pkg::FK_END)
                begin
                    phase_reg <= ibwt_pkg::PH_DONE;
                end
            end
            if (cmd.fetch_out)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
        end
    end

endmodule
